// File: hdl/pfe_pkg.sv
// Shared constants, op codes and types for the palette fade engine.
package pfe_pkg;

    localparam int PAL_SIZE    = 256;
    localparam int IDX_W       = $clog2(PAL_SIZE);
    localparam int CNT_W       = $clog2(PAL_SIZE + 1);
    localparam int INDEX_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int COLOR_W     = CHAN_W * NUM_CHAN;
    localparam int WIDTH_W     = 13;
    localparam int COORD_W     = 12;
    localparam int ADDR_W      = 26;
    localparam int PIX_SHIFT   = 2;
    localparam int LIN_W       = ADDR_W - PIX_SHIFT;
    localparam int OP_W        = 3;
    localparam int MAX_WIDTH   = 4096;
    localparam int WIDTH_RESET = 640;

    localparam logic [OP_W-1:0] OP_SET       = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_TGT   = 3'd1;
    localparam logic [OP_W-1:0] OP_FADE_TGT  = 3'd2;
    localparam logic [OP_W-1:0] OP_FADE_BLK  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;
    localparam logic [OP_W-1:0] OP_PIXEL     = 3'd5;

    typedef logic [COLOR_W-1:0] t_color;

    typedef struct packed {
        t_color cur;
        t_color goal;
    } t_step_req;

    typedef struct packed {
        t_color nxt;
        logic   changed;
    } t_step_rsp;

endpackage

// File: hdl/palette_fade_engine.sv
// Palette fade engine: palette and target stores, fade sequencer and pixel address path.
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) and each one gives
// exactly one result on the output channel (o_out_valid / i_out_stall). The block
// works on one request at a time and stalls its input while busy, so it takes no new
// request before the last one has moved its result into the output register.
// Set, read and pixel requests read the palette store when taken, then form the
// result into the output register in the execute state. A pixel request multiplies
// the row by the screen width in that execute state.
// A fade request walks every palette entry through the single step unit, one entry
// per cycle with the read and write-back overlapped, then enters the execute state
// to register its result.
// The output register holds a result while i_out_stall is high; the next request
// is still taken meanwhile and waits to deliver until the register frees up.
// Screen width is written through i_cfg_we / i_cfg_wdata; the user must do so only while the
// block is idle, which the block itself does not enforce. Values above MAX_WIDTH are held as MAX_WIDTH.
// Reset is synchronous: the palette reads as black at once through per-entry valid
// bits, so no clearing pass is needed. The target store is not cleared and must be
// written before a fade to target uses it. Screen width returns to 640.
module palette_fade_engine
    import pfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WIDTH_W-1:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [INDEX_W-1:0]   i_palette_index,
    input  logic [COLOR_W-1:0]   i_entry_color,
    input  logic [COORD_W-1:0]   i_pixel_x,
    input  logic [COORD_W-1:0]   i_pixel_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [COLOR_W-1:0]   o_color,
    output logic [ADDR_W-1:0]    o_pixel_address,
    output logic                 o_pixel_write,
    output logic                 o_faded
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FADE = 2'd2;

    t_color mem_cur [PAL_SIZE];
    t_color mem_tgt [PAL_SIZE];

    logic [PAL_SIZE-1:0] r_cur_vld;
    logic                r_cur_rd_vld;
    t_color              r_cur_rd;
    t_color              r_tgt_rd;

    logic [1:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [IDX_W-1:0]    r_addr, n_addr;
    logic                r_idx_ok, n_idx_ok;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_wb_vld, n_wb_vld;
    logic [IDX_W-1:0]    r_wb_addr, n_wb_addr;
    logic                r_changed, n_changed;
    logic [WIDTH_W-1:0]  r_width, n_width;

    logic                r_out_vld, n_out_vld;
    t_color              r_out_color, n_out_color;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic                r_out_pwr, n_out_pwr;
    logic                r_out_faded, n_out_faded;

    logic                accept;
    logic                idx_ok;
    logic                fade_done;
    logic [IDX_W-1:0]    rd_addr;
    logic                cur_we;
    logic [IDX_W-1:0]    cur_waddr;
    t_color              cur_wdata;
    logic                tgt_we;
    t_step_req           step_req;
    t_step_rsp           step_rsp;
    logic [COORD_W+WIDTH_W-1:0] row_prod;
    logic [LIN_W-1:0]    lin_addr;
    t_color              entry_color;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign idx_ok     = ({1'b0, i_palette_index} < (INDEX_W + 1)'(PAL_SIZE));
    assign fade_done  = (r_cnt == CNT_W'(PAL_SIZE));
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        case (r_state)
            ST_IDLE: rd_addr = i_palette_index[IDX_W-1:0];
            ST_FADE: rd_addr = r_cnt[IDX_W-1:0];
            default: rd_addr = r_addr;
        endcase
    end

    assign cur_we    = (accept && (i_op == OP_SET) && idx_ok)
                     || ((r_state == ST_FADE) && r_wb_vld);
    assign cur_waddr = (r_state == ST_FADE) ? r_wb_addr : i_palette_index[IDX_W-1:0];
    assign cur_wdata = (r_state == ST_FADE) ? step_rsp.nxt : i_entry_color;
    assign tgt_we    = accept && (i_op == OP_SET_TGT) && idx_ok;

    assign entry_color   = r_cur_rd_vld ? r_cur_rd : '0;
    assign step_req.cur  = entry_color;
    assign step_req.goal = (r_op == OP_FADE_BLK) ? '0 : r_tgt_rd;

    pfe_step_unit u_step (
        .i_req (step_req),
        .o_rsp (step_rsp)
    );

    // Byte address wraps to its field width, so only the low bits of the line sum count.
    assign row_prod = (COORD_W + WIDTH_W)'(r_y) * (COORD_W + WIDTH_W)'(r_width);
    assign lin_addr = LIN_W'(row_prod) + LIN_W'(r_x);

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            mem_cur[cur_waddr] <= cur_wdata;
        end
        r_cur_rd <= mem_cur[rd_addr];
        if (tgt_we) begin
            mem_tgt[i_palette_index[IDX_W-1:0]] <= i_entry_color;
        end
        r_tgt_rd     <= mem_tgt[rd_addr];
        r_cur_rd_vld <= r_cur_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= '0;
        end else if (cur_we) begin
            r_cur_vld[cur_waddr] <= 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_addr      = r_addr;
        n_idx_ok    = r_idx_ok;
        n_x         = r_x;
        n_y         = r_y;
        n_cnt       = r_cnt;
        n_wb_vld    = r_wb_vld;
        n_wb_addr   = r_wb_addr;
        n_changed   = r_changed;
        n_width     = r_width;
        n_out_vld   = r_out_vld;
        n_out_color = r_out_color;
        n_out_addr  = r_out_addr;
        n_out_pwr   = r_out_pwr;
        n_out_faded = r_out_faded;

        if (i_cfg_we) begin
            n_width = (i_cfg_wdata > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : i_cfg_wdata;
        end

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op     = i_op;
                    n_addr   = i_palette_index[IDX_W-1:0];
                    n_idx_ok = idx_ok;
                    n_x      = i_pixel_x;
                    n_y      = i_pixel_y;
                    if (i_op inside {OP_FADE_TGT, OP_FADE_BLK}) begin
                        n_state   = ST_FADE;
                        n_cnt     = '0;
                        n_wb_vld  = 1'b0;
                        n_changed = 1'b0;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_FADE: begin
                // Entry r_cnt is read while the previous entry is written back.
                n_wb_vld  = !fade_done;
                n_wb_addr = r_cnt[IDX_W-1:0];
                if (!fade_done) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_wb_vld && step_rsp.changed) begin
                    n_changed = 1'b1;
                end
                if (fade_done && !r_wb_vld) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_out_color = ((r_op inside {OP_READ, OP_PIXEL}) && r_idx_ok)
                                ? entry_color : '0;
                    n_out_addr  = (r_op == OP_PIXEL) ? {lin_addr, PIX_SHIFT'(0)} : '0;
                    n_out_pwr   = (r_op == OP_PIXEL);
                    n_out_faded = (r_op inside {OP_FADE_TGT, OP_FADE_BLK}) && !r_changed;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_width   <= WIDTH_W'(WIDTH_RESET);
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_wb_vld  <= n_wb_vld;
            r_width   <= n_width;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_idx_ok    <= n_idx_ok;
        r_x         <= n_x;
        r_y         <= n_y;
        r_cnt       <= n_cnt;
        r_wb_addr   <= n_wb_addr;
        r_changed   <= n_changed;
        r_out_color <= n_out_color;
        r_out_addr  <= n_out_addr;
        r_out_pwr   <= n_out_pwr;
        r_out_faded <= n_out_faded;
    end

    assign o_out_valid     = r_out_vld;
    assign o_color         = r_out_color;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_write   = r_out_pwr;
    assign o_faded         = r_out_faded;

endmodule

// File: hdl/pfe_step_unit.sv
// Fade step unit: moves each channel of one entry a single count toward its goal.
module pfe_step_unit
    import pfe_pkg::*;
(
    input  t_step_req i_req,
    output t_step_rsp o_rsp
);

    always_comb begin
        logic [CHAN_W-1:0] c;
        logic [CHAN_W-1:0] g;
        o_rsp.nxt     = '0;
        o_rsp.changed = 1'b0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            c = i_req.cur[k*CHAN_W +: CHAN_W];
            g = i_req.goal[k*CHAN_W +: CHAN_W];
            if (c > g) begin
                c             = c - CHAN_W'(1);
                o_rsp.changed = 1'b1;
            end else if (c < g) begin
                c             = c + CHAN_W'(1);
                o_rsp.changed = 1'b1;
            end
            o_rsp.nxt[k*CHAN_W +: CHAN_W] = c;
        end
    end

endmodule

// File: hdl/pfe_checker.sv
// Port-level checker for the palette fade engine, bound to the top level.
module pfe_checker
    import pfe_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [COLOR_W-1:0]   o_color,
    input logic [ADDR_W-1:0]    o_pixel_address,
    input logic                 o_pixel_write,
    input logic                 o_faded
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_color)
                                     && $stable(o_pixel_address))
        else $error("stalled result changed or was dropped");

    // The engine works on one request at a time, so it must be busy right after taking one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one still in progress");

    a_addr_only_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_write |-> o_pixel_address == '0)
        else $error("address reported for a request that is not a pixel write");

    a_pixel_not_faded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pixel_write |-> !o_faded)
        else $error("faded flag raised on a pixel result");

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (.*);

// File: verif/palette_fade_engine_tb.sv
// Self-checking testbench for the palette fade engine: palette and target writes, fades, reads and pixel addresses.
module palette_fade_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    // Op codes that the block leaves unused.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_WAIT      = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int CHAN_MAX      = (1 << CHAN_W) - 1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
        t_color             color;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_pfe_request;

    typedef struct packed {
        t_color            color;
        logic [ADDR_W-1:0] address;
        logic              pixel_write;
        logic              faded;
    } t_pfe_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [WIDTH_W-1:0]   i_cfg_wdata     = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op            = '0;
    logic [INDEX_W-1:0]   i_palette_index = '0;
    logic [COLOR_W-1:0]   i_entry_color   = '0;
    logic [COORD_W-1:0]   i_pixel_x       = '0;
    logic [COORD_W-1:0]   i_pixel_y       = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [COLOR_W-1:0]   o_color;
    logic [ADDR_W-1:0]    o_pixel_address;
    logic                 o_pixel_write;
    logic                 o_faded;

    // Shadow copy of the block's state, advanced as each request is accepted.
    t_color             palette_shadow [PAL_SIZE];
    t_color             target_shadow  [PAL_SIZE];
    logic [WIDTH_W-1:0] width_shadow;
    t_pfe_result        pending_results [$];
    int                 mismatches  = 0;
    int                 idle_cycles = 0;
    bit                 calm        = 1'b0;
    logic               last_faded  = 1'b0;

    palette_fade_engine u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_palette_index (i_palette_index),
        .i_entry_color   (i_entry_color),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_color         (o_color),
        .o_pixel_address (o_pixel_address),
        .o_pixel_write   (o_pixel_write),
        .o_faded         (o_faded)
    );

    always #1 i_clk = ~i_clk;

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic t_step_rsp step_channels(t_color cur, t_color goal);
        t_step_rsp rsp;
        rsp.nxt     = cur;
        rsp.changed = 1'b0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (cur[c*CHAN_W +: CHAN_W] > goal[c*CHAN_W +: CHAN_W]) begin
                rsp.nxt[c*CHAN_W +: CHAN_W] = cur[c*CHAN_W +: CHAN_W] - CHAN_W'(1);
                rsp.changed = 1'b1;
            end else if (cur[c*CHAN_W +: CHAN_W] < goal[c*CHAN_W +: CHAN_W]) begin
                rsp.nxt[c*CHAN_W +: CHAN_W] = cur[c*CHAN_W +: CHAN_W] + CHAN_W'(1);
                rsp.changed = 1'b1;
            end
        end
        return rsp;
    endfunction

    // One fade step over the whole palette; returns 1 when nothing moved.
    function automatic logic fade_palette(bit to_black);
        t_step_rsp rsp;
        logic      moved;
        moved = 1'b0;
        for (int i = 0; i < PAL_SIZE; i++) begin
            rsp = step_channels(palette_shadow[i], to_black ? t_color'(0) : target_shadow[i]);
            palette_shadow[i] = rsp.nxt;
            moved |= rsp.changed;
        end
        return !moved;
    endfunction

    function automatic t_pfe_result predict_result(t_pfe_request req);
        t_pfe_result res;
        logic [63:0] w;
        res = '0;
        case (req.op)
            OP_SET:      palette_shadow[req.index] = req.color;
            OP_SET_TGT:  target_shadow[req.index] = req.color;
            OP_FADE_TGT: res.faded = fade_palette(1'b0);
            OP_FADE_BLK: res.faded = fade_palette(1'b1);
            OP_READ:     res.color = palette_shadow[req.index];
            OP_PIXEL: begin
                w = (width_shadow > MAX_WIDTH) ? 64'(MAX_WIDTH) : 64'(width_shadow);
                res.color       = palette_shadow[req.index];
                res.address     = ADDR_W'((64'(req.x) << PIX_SHIFT) +
                                          ((64'(req.y) * w) << PIX_SHIFT));
                res.pixel_write = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_pfe_request make_request(logic [OP_W-1:0] op, int unsigned index,
                                                  int unsigned color, int unsigned x,
                                                  int unsigned y);
        t_pfe_request req;
        req.op    = op;
        req.index = INDEX_W'(index);
        req.color = COLOR_W'(color);
        req.x     = COORD_W'(x);
        req.y     = COORD_W'(y);
        return req;
    endfunction

    function automatic t_pfe_request random_request();
        logic [OP_W-1:0] op;
        int unsigned     pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_SET;
        else if (pick < 45) op = OP_SET_TGT;
        else if (pick < 65) op = OP_READ;
        else if (pick < 90) op = OP_PIXEL;
        else if (pick < 93) op = OP_FADE_TGT;
        else if (pick < 96) op = OP_FADE_BLK;
        else if (pick < 98) op = OP_SPARE_6;
        else                op = OP_SPARE_7;
        return make_request(op, $urandom_range(0, PAL_SIZE - 1), $urandom, $urandom, $urandom);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(t_pfe_request req);
        int          gap;
        t_pfe_result res;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= req.op;
        i_palette_index <= req.index;
        i_entry_color   <= req.color;
        i_pixel_x       <= req.x;
        i_pixel_y       <= req.y;
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        @(posedge i_clk);
        res = predict_result(req);
        last_faded = res.faded;
        pending_results.push_back(res);
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_screen_width(int unsigned value);
        drain_requests();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= WIDTH_W'(value);
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        width_shadow  = WIDTH_W'(value);
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic check_result();
        t_pfe_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request outstanding", '0, 32'(o_color));
        end else begin
            want = pending_results.pop_front();
            if (o_color !== want.color)
                report_mismatch("color", 32'(want.color), 32'(o_color));
            if (o_pixel_address !== want.address)
                report_mismatch("pixel_address", 32'(want.address), 32'(o_pixel_address));
            if (o_pixel_write !== want.pixel_write)
                report_mismatch("pixel_write", 32'(want.pixel_write), 32'(o_pixel_write));
            if (o_faded !== want.faded)
                report_mismatch("faded", 32'(want.faded), 32'(o_faded));
        end
    endtask

    // Outputs are sampled on the falling edge, where they are settled for the coming rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            check_result();
    end

    always @(negedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("palette_fade_engine_tb: errors");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(negedge i_clk); while (o_out_valid !== 1'b1);
            @(posedge i_clk);
        end
    end

    // After reset the palette reads black, so a fade to black has nothing to move.
    task automatic test_reset_state();
        send_request(make_request(OP_READ, 0, 0, 0, 0));
        send_request(make_request(OP_READ, PAL_SIZE - 1, 0, 0, 0));
        send_request(make_request(OP_FADE_BLK, 0, 0, 0, 0));
        send_request(make_request(OP_PIXEL, 7, 0, 3, 2));
        send_request(make_request(OP_SPARE_6, 'h5A, 'h123456, 'hFFF, 'hFFF));
        send_request(make_request(OP_SPARE_7, 'h5A, 'hFEDCBA, 'h555, 'hAAA));
        send_request(make_request(OP_READ, 'h5A, 0, 0, 0));
    endtask

    task automatic test_field_extremes();
        send_request(make_request(OP_SET, PAL_SIZE - 1, 'hFFFFFF, 0, 0));
        send_request(make_request(OP_SET, 0, 'h000001, 0, 0));
        send_request(make_request(OP_SET, 'hAA, 'hAAAAAA, 0, 0));
        send_request(make_request(OP_SET, 'h55, 'h555555, 0, 0));
        send_request(make_request(OP_READ, PAL_SIZE - 1, 0, 0, 0));
        send_request(make_request(OP_READ, 'hAA, 0, 0, 0));
        send_request(make_request(OP_READ, 'h55, 0, 0, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0));
        send_request(make_request(OP_PIXEL, PAL_SIZE - 1, 0, 'hFFF, 'hFFF));
        send_request(make_request(OP_PIXEL, 'hAA, 0, 'hAAA, 'h555));
        send_request(make_request(OP_FADE_BLK, 0, 0, 0, 0));
        send_request(make_request(OP_READ, PAL_SIZE - 1, 0, 0, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0));
    endtask

    // Every target entry is loaded before the first fade to target reads them.
    task automatic test_target_preload();
        int unsigned col;
        for (int i = 0; i < PAL_SIZE; i++) begin
            if (i == 0)                 col = 'hFFFFFF;
            else if (i == PAL_SIZE - 1) col = 0;
            else                        col = $urandom;
            send_request(make_request(OP_SET_TGT, i, col, $urandom, $urandom));
        end
        repeat (3) send_request(make_request(OP_FADE_TGT, $urandom, $urandom, $urandom, $urandom));
    endtask

    // Zero, one, the maximum, values beyond it that are clipped, the register's top value and the reset value.
    task automatic test_screen_width();
        int unsigned widths [7] = '{0, 1, MAX_WIDTH, MAX_WIDTH + 1, (1 << WIDTH_W) - 1, 5461,
                                    WIDTH_RESET};
        foreach (widths[k]) begin
            set_screen_width(widths[k]);
            calm = (k % 2) == 1;
            send_request(make_request(OP_PIXEL, $urandom, 0, 'hFFF, 'hFFF));
            send_request(make_request(OP_PIXEL, $urandom, 0, 0, 1));
            send_request(make_request(OP_PIXEL, $urandom, 0, 1, 0));
            repeat (7) send_request(make_request(OP_PIXEL, $urandom, $urandom, $urandom, $urandom));
        end
        calm = 1'b0;
    endtask

    // Targets placed within 3 counts of the palette so that fades run to completion.
    task automatic test_fade_convergence();
        t_color cur;
        t_color goal;
        int     lvl;
        for (int i = 0; i < PAL_SIZE; i++) begin
            cur = palette_shadow[i];
            for (int c = 0; c < NUM_CHAN; c++) begin
                lvl = int'(cur[c*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 6)) - 3;
                if (lvl < 0) lvl = 0;
                if (lvl > CHAN_MAX) lvl = CHAN_MAX;
                goal[c*CHAN_W +: CHAN_W] = CHAN_W'(lvl);
            end
            send_request(make_request(OP_SET_TGT, i, 32'(goal), $urandom, $urandom));
        end
        do send_request(make_request(OP_FADE_TGT, $urandom, 0, 0, 0)); while (!last_faded);
        send_request(make_request(OP_FADE_TGT, $urandom, 0, 0, 0));

        for (int i = 0; i < PAL_SIZE; i++) begin
            for (int c = 0; c < NUM_CHAN; c++)
                goal[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(0, 2));
            send_request(make_request(OP_SET, i, 32'(goal), $urandom, $urandom));
        end
        do send_request(make_request(OP_FADE_BLK, $urandom, 0, 0, 0)); while (!last_faded);
        send_request(make_request(OP_FADE_BLK, $urandom, 0, 0, 0));
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 4; chunk++) begin
            if (chunk == 0) set_screen_width($urandom_range(0, (1 << WIDTH_W) - 1));
            else            set_screen_width($urandom_range(1, MAX_WIDTH));
            calm = (chunk == 2);
            repeat (250) send_request(random_request());
        end
        calm = 1'b0;
    endtask

    initial begin
        width_shadow = WIDTH_W'(WIDTH_RESET);
        foreach (palette_shadow[i]) palette_shadow[i] = '0;
        foreach (target_shadow[i]) target_shadow[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_target_preload();
        test_screen_width();
        test_fade_convergence();
        test_random_traffic();

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("palette_fade_engine_tb: clean");
        else
            $display("palette_fade_engine_tb: errors");
        $finish;
    end

endmodule
